@@ rtl/core/bdqs_pkg.sv @@
// ----------------------------------------------------------------------------
// bdqs_pkg: shared types for the bounded deque with search
// Command and status codes, the result transaction layout, controller states
// and the per-cycle control word broadcast to every storage cell.
// ----------------------------------------------------------------------------
package bdqs_pkg;

   localparam int VALUE_W = 32;
   localparam int FIELD_W = 5;   // width of the position and size result fields
   localparam int CMD_W   = 3;
   localparam int RSP_W   = 80;  // result tdata, padded to whole bytes

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_FIND       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,   // take the lower neighbor's value (toward the back)
      CELL_SHIFT_DOWN = 2'd2,   // take the upper neighbor's value (toward the front)
      CELL_WRITE      = 2'd3    // selected cell takes the request value
   } cell_op_type;

   typedef enum logic [1:0] {
      SCAN_HOLD  = 2'd0,
      SCAN_LOAD  = 2'd1,        // copy the stored value into the scan line
      SCAN_SHIFT = 2'd2         // move the scan line one cell toward the front
   } scan_op_type;

   typedef struct packed {
      cell_op_type cell_op;
      scan_op_type scan_op;
   } cell_ctrl_type;

   typedef struct packed {
      value_type          back;
      logic [FIELD_W-1:0] size;
      logic [FIELD_W-1:0] position;
      value_type          popped;
      status_type         status;
   } result_type;

endpackage

@@ rtl/core/bdqs_cell.sv @@
// ----------------------------------------------------------------------------
// bdqs_cell: one storage cell of the deque chain
// Holds one stored value and one scan-line value; both move to or from the
// neighboring cells as the broadcast control word tells.
// ----------------------------------------------------------------------------
module bdqs_cell (
   input  logic                   clock,
   input  bdqs_pkg::cell_ctrl_type ctrl,
   input  logic                   write_sel,
   input  bdqs_pkg::value_type    write_value,
   input  bdqs_pkg::value_type    lower_value,
   input  bdqs_pkg::value_type    upper_value,
   input  bdqs_pkg::value_type    upper_scan,
   output bdqs_pkg::value_type    value_out,
   output bdqs_pkg::value_type    scan_out
);
   import bdqs_pkg::*;

   value_type value_ff, value_in;
   value_type scan_ff, scan_in;

   // select the next stored value
   always_comb begin
      value_in = value_ff;
      case (ctrl.cell_op)
         CELL_SHIFT_UP:   value_in = lower_value;
         CELL_SHIFT_DOWN: value_in = upper_value;
         CELL_WRITE:      value_in = write_sel ? write_value : value_ff;
         default:         value_in = value_ff;
      endcase
   end

   // select the next scan-line value
   always_comb begin
      scan_in = scan_ff;
      case (ctrl.scan_op)
         SCAN_LOAD:  scan_in = value_ff;
         SCAN_SHIFT: scan_in = upper_scan;
         default:    scan_in = scan_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      scan_ff  <= scan_in;
   end

   assign value_out = value_ff;
   assign scan_out  = scan_ff;

endmodule

@@ rtl/core/bdqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdqs_ctrl: command sequencer for the deque chain
// Tracks occupancy and the back value, drives the cell chain, walks the scan
// line for find and pop-back, and buffers results in a two-entry skid.
// ----------------------------------------------------------------------------
module bdqs_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bdqs_pkg::CMD_W-1:0]          req_tuser,
   input  bdqs_pkg::value_type                 req_value,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output bdqs_pkg::result_type                rsp_result,
   output bdqs_pkg::cell_ctrl_type             cell_ctrl,
   output logic [$clog2(CAPACITY+1)-1:0]       occupancy,
   input  bdqs_pkg::value_type                 front_value,
   input  bdqs_pkg::value_type                 scan_head
);
   import bdqs_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   value_type          back_ff, back_in;
   value_type          popped_ff, popped_in;
   value_type          key_ff, key_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               scan_pop_ff, scan_pop_in;
   logic               out_valid_ff;
   result_type         out_ff;
   logic               hold_valid_ff;
   result_type         hold_ff;

   cmd_type            cmd;
   logic               accept;
   logic               is_empty;
   logic               is_full;
   logic               at_last;
   logic               key_hit;
   logic               scan_start;
   logic               scan_done;
   logic               out_free;
   logic               res_valid;
   result_type         res;

   assign cmd        = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && !hold_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_empty   = (occ_ff == '0);
   assign is_full    = (occ_ff == CNT_W'(CAPACITY));
   assign at_last    = (CNT_W'(idx_ff) == occ_ff - CNT_W'(1));
   assign key_hit    = (scan_head == key_ff);

   // decide when a walk of the scan line starts and ends
   always_comb begin
      scan_start = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_FIND:     scan_start = !is_empty;
            CMD_POP_BACK: scan_start = (occ_ff > CNT_W'(1));
            default:      scan_start = 1'b0;
         endcase
      end
      scan_done = (state_ff == ST_SCAN) && (at_last || (key_hit && !scan_pop_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: state_in = scan_start ? ST_SCAN : ST_IDLE;
         ST_SCAN: state_in = scan_done ? ST_IDLE : ST_SCAN;
         default: state_in = ST_IDLE;
      endcase
   end

   // chain control, bookkeeping and result
   always_comb begin
      cell_ctrl.cell_op = CELL_HOLD;
      cell_ctrl.scan_op = SCAN_HOLD;
      occ_in            = occ_ff;
      back_in           = back_ff;
      popped_in         = popped_ff;
      key_in            = key_ff;
      idx_in            = idx_ff;
      scan_pop_in       = scan_pop_ff;
      res_valid         = 1'b0;
      res.status        = STAT_OK;
      res.popped        = '0;
      res.position      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in      = req_value;
               idx_in      = '0;
               scan_pop_in = 1'b0;
               res_valid   = !scan_start;
               case (cmd)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        res.status = STAT_FULL;
                     end else begin
                        cell_ctrl.cell_op = CELL_SHIFT_UP;
                        occ_in            = occ_ff + CNT_W'(1);
                        back_in           = is_empty ? req_value : back_ff;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (is_full) begin
                        res.status = STAT_FULL;
                     end else begin
                        cell_ctrl.cell_op = CELL_WRITE;
                        occ_in            = occ_ff + CNT_W'(1);
                        back_in           = req_value;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        cell_ctrl.cell_op = CELL_SHIFT_DOWN;
                        res.popped        = front_value;
                        occ_in            = occ_ff - CNT_W'(1);
                        back_in           = (occ_ff == CNT_W'(1)) ? '0 : back_ff;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        res.popped        = back_ff;
                        popped_in         = back_ff;
                        occ_in            = occ_ff - CNT_W'(1);
                        scan_pop_in       = 1'b1;
                        cell_ctrl.scan_op = SCAN_LOAD;
                        if (occ_ff == CNT_W'(1)) begin
                           back_in = '0;
                        end
                     end
                  end
                  CMD_FIND: begin
                     if (is_empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        cell_ctrl.scan_op = SCAN_LOAD;
                     end
                  end
                  default: res.status = STAT_OK;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_pop_ff) begin
               // the new back sits at the last occupied position
               if (at_last) begin
                  res_valid  = 1'b1;
                  res.popped = popped_ff;
                  back_in    = scan_head;
               end else begin
                  cell_ctrl.scan_op = SCAN_SHIFT;
                  idx_in            = idx_ff + IDX_W'(1);
               end
            end else if (key_hit) begin
               res_valid    = 1'b1;
               res.position = FIELD_W'(CNT_W'(idx_ff) + CNT_W'(1));
            end else if (at_last) begin
               res_valid  = 1'b1;
               res.status = STAT_NOT_FOUND;
            end else begin
               cell_ctrl.scan_op = SCAN_SHIFT;
               idx_in            = idx_ff + IDX_W'(1);
            end
         end
         default: res_valid = 1'b0;
      endcase
      res.size = FIELD_W'(occ_in);
      res.back = back_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         back_ff  <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         back_ff  <= back_in;
      end
   end

   // per-command working registers
   always_ff @(posedge clock) begin
      popped_ff   <= popped_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      scan_pop_ff <= scan_pop_in;
   end

   // output register with a skid entry behind it
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (hold_valid_ff) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         hold_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= hold_valid_ff ? hold_ff : res;
      end else if (res_valid) begin
         hold_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;
   assign occupancy  = occ_ff;

endmodule

@@ rtl/core/bounded_deque_with_search_core.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core: bounded deque of signed 32-bit values
// Push and pop at both ends plus a search from the front, built as a chain
// of register cells with a scan line that walks toward the front.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): tuser carries the command, tdata the value.
//   Response channel (rsp_*): one transaction per request; tuser carries the
//   status, tdata the popped value, position, size and back value.
//   Push front, push back, pop front and every refused or unused command
//   finish in the cycle they are accepted, so they run back to back at one
//   per cycle while the skid entry is free; the response is registered.
//   Find walks the scan line one cell per cycle from the front until a hit
//   or the last stored value. Pop back walks the scan line to the new back
//   entry after the pop, with no walk when the pop empties the deque.
//   A new request is taken once the previous one has finished; a finished
//   response waits in the output register while the next request runs, and a
//   second one waits in a skid entry, which holds off further requests.
//   Reset empties the deque and drops pending responses; stored cell values
//   are not cleared. The receiver may stall rsp_tready without loss.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bdqs_pkg::CMD_W-1:0]   req_tuser,   // [2:0] command
   input  logic [bdqs_pkg::VALUE_W-1:0] req_tdata,   // [31:0] value
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [1:0]                   rsp_tuser,   // [1:0] status
   // [31:0] popped_value, [36:32] position, [41:37] size_now,
   // [73:42] back_value, [79:74] zero
   output logic [bdqs_pkg::RSP_W-1:0]   rsp_tdata
);
   import bdqs_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PAD_W = RSP_W - (2 * VALUE_W + 2 * FIELD_W);

   cell_ctrl_type    cell_ctrl;
   logic [CNT_W-1:0] occupancy;
   result_type       result;
   value_type        req_value;
   value_type        cell_value [CAPACITY];
   value_type        cell_scan  [CAPACITY];

   assign req_value = value_type'(req_tdata);

   bdqs_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_value  (req_value),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result),
      .cell_ctrl  (cell_ctrl),
      .occupancy  (occupancy),
      .front_value(cell_value[0]),
      .scan_head  (cell_scan[0])
   );

   // cell 0 is the front; values move up on push front, down on pop front
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type lower_value;
      value_type upper_value;
      value_type upper_scan;

      if (i == 0) begin : g_front
         assign lower_value = req_value;
      end else begin : g_inner_low
         assign lower_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign upper_value = '0;
         assign upper_scan  = '0;
      end else begin : g_inner_high
         assign upper_value = cell_value[i+1];
         assign upper_scan  = cell_scan[i+1];
      end

      bdqs_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .write_sel  (occupancy == CNT_W'(i)),
         .write_value(req_value),
         .lower_value(lower_value),
         .upper_value(upper_value),
         .upper_scan (upper_scan),
         .value_out  (cell_value[i]),
         .scan_out   (cell_scan[i])
      );
   end

   // pack the response transaction
   assign rsp_tuser = result.status;
   assign rsp_tdata = {{PAD_W{1'b0}}, result.back, result.size, result.position,
                       result.popped};

endmodule

@@ rtl/core/bdqs_checker.sv @@
// ----------------------------------------------------------------------------
// bdqs_checker: port-level checks for the deque core
// Watches the request and response channels and flags responses whose
// fields contradict each other, plus stall stability and quiet after reset.
// ----------------------------------------------------------------------------
module bdqs_checker #(
   parameter int CAPACITY = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [bdqs_pkg::CMD_W-1:0]   req_tuser,
   input logic [bdqs_pkg::VALUE_W-1:0] req_tdata,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [1:0]                   rsp_tuser,
   input logic [bdqs_pkg::RSP_W-1:0]   rsp_tdata
);
   import bdqs_pkg::*;

   logic [FIELD_W-1:0] rsp_position;
   logic [FIELD_W-1:0] rsp_size;
   logic [VALUE_W-1:0] rsp_back;
   logic               req_seen;

   assign rsp_position = rsp_tdata[36:32];
   assign rsp_size     = rsp_tdata[41:37];
   assign rsp_back     = rsp_tdata[73:42];
   assign req_seen     = req_tvalid && req_tready && (req_tuser != '1) && (req_tdata != '1);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // empty status only with an empty deque
   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_EMPTY) |-> (rsp_size == '0) && (rsp_back == '0))
      else $error("empty status with stored values");

   // a position is reported only by a successful find
   a_position_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_position != '0) |-> (rsp_tuser == STAT_OK)
         && (CAPACITY > 31 || rsp_position <= rsp_size))
      else $error("position outside the stored values");

   // an empty deque shows a zero back value
   a_back_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_size == '0) && !req_seen |-> (CAPACITY > 31) || (rsp_back == '0))
      else $error("nonzero back value with an empty deque");

endmodule

bind bounded_deque_with_search_core bdqs_checker #(
   .CAPACITY(CAPACITY)
) u_bdqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tuser (rsp_tuser),
   .rsp_tdata (rsp_tdata)
);

@@ bench/deque_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker: scoreboard for the bounded deque with search
// Watches both stream channels. Each accepted request is applied to a local
// copy of the deque; the resulting status, popped value, position, size and
// back value are queued and compared field by field with the next response.
// ----------------------------------------------------------------------------
module deque_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [bdqs_pkg::CMD_W-1:0]   req_tuser,   // [2:0] command
   input  logic [bdqs_pkg::VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [1:0]                   rsp_tuser,   // [1:0] status
   // [31:0] popped_value, [36:32] position, [41:37] size_now,
   // [73:42] back_value, [79:74] zero
   input  logic [bdqs_pkg::RSP_W-1:0]   rsp_tdata,
   output int                           error_count,
   output int                           outcomes_waiting
);
   import bdqs_pkg::*;

   typedef struct packed {
      status_type         status;
      value_type          popped;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] size;
      value_type          back;
   } outcome_type;

   // local copy of the deque, front at index 0
   value_type   cells [CAPACITY];
   int unsigned occupancy;

   outcome_type expected_outcomes [$];
   outcome_type oldest;
   int          response_count;

   // apply one command to the local deque and return what the block must answer
   function automatic outcome_type apply_command(logic [CMD_W-1:0] cmd, value_type val);
      outcome_type o;
      int unsigned i;
      o = '0;
      o.status = STAT_OK;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (occupancy >= CAPACITY) begin
               o.status = STAT_FULL;
            end else begin
               for (i = occupancy; i > 0; i--) cells[i] = cells[i-1];
               cells[0] = val;
               occupancy++;
            end
         end
         CMD_PUSH_BACK: begin
            if (occupancy >= CAPACITY) begin
               o.status = STAT_FULL;
            end else begin
               cells[occupancy] = val;
               occupancy++;
            end
         end
         CMD_POP_FRONT: begin
            if (occupancy == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               o.popped = cells[0];
               for (i = 0; i + 1 < occupancy; i++) cells[i] = cells[i+1];
               occupancy--;
            end
         end
         CMD_POP_BACK: begin
            if (occupancy == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               o.popped = cells[occupancy-1];
               occupancy--;
            end
         end
         CMD_FIND: begin
            if (occupancy == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               // first match from the front wins
               o.status = STAT_NOT_FOUND;
               for (i = 0; i < occupancy; i++) begin
                  if (o.position == 0 && cells[i] == val) begin
                     o.position = FIELD_W'(i + 1);
                     o.status   = STAT_OK;
                  end
               end
            end
         end
         default: begin
            // unused codes leave the deque alone
         end
      endcase
      o.size = FIELD_W'(occupancy);
      o.back = (occupancy == 0) ? value_type'(0) : cells[occupancy-1];
      return o;
   endfunction

   // print one mismatch line (capped) and count it
   task automatic report(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
      error_count++;
      if (error_count <= 100)
         $display("%0t: response %0d %s got %0h expected %0h",
                  $time, response_count, field, got, want);
   endtask

   // check responses first: a request taken at this edge answers later
   always @(posedge clock) begin
      if (reset) begin
         occupancy = 0;
         expected_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               report("unexpected transaction", rsp_tdata[31:0], '0);
            end else begin
               oldest = expected_outcomes.pop_front();
               if (rsp_tuser !== oldest.status)
                  report("status", rsp_tuser, oldest.status);
               if (rsp_tdata[31:0] !== oldest.popped)
                  report("popped_value", rsp_tdata[31:0], oldest.popped);
               if (rsp_tdata[36:32] !== oldest.position)
                  report("position", rsp_tdata[36:32], oldest.position);
               if (rsp_tdata[41:37] !== oldest.size)
                  report("size_now", rsp_tdata[41:37], oldest.size);
               if (rsp_tdata[73:42] !== oldest.back)
                  report("back_value", rsp_tdata[73:42], oldest.back);
               if (rsp_tdata[79:74] !== '0)
                  report("padding", rsp_tdata[79:74], '0);
            end
            response_count++;
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(apply_command(req_tuser, req_tdata));
      end
      outcomes_waiting = expected_outcomes.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bounded deque with search
// Drives directed corner cases, then runs of fill, drain, mixed and search
// traffic with random gaps on the request side and random stalls on the
// response side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import bdqs_pkg::*;

   localparam int CAPACITY = 16;
   localparam int ITEM_GOAL = 1350;
   localparam logic [CMD_W-1:0] FIRST_UNUSED_CMD = 3'd5;
   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_SEARCH} run_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [CMD_W-1:0]     req_tuser;
   logic [VALUE_W-1:0]   req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [1:0]           rsp_tuser;
   logic [RSP_W-1:0]     rsp_tdata;

   int        error_count;
   int        outcomes_waiting;
   int        gap_max;
   int        stall_max;
   int        items_sent;
   value_type value_pool [8];

   bounded_deque_with_search_core #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

   deque_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .outcomes_waiting(outcomes_waiting)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly pool values so that finds hit and duplicates appear
   function automatic value_type pick_value();
      if ($urandom_range(0, 3) != 0)
         return value_pool[$urandom_range(0, 7)];
      return value_type'($urandom);
   endfunction

   // present one request after a random gap and hold it until accepted
   task automatic send(logic [CMD_W-1:0] cmd, value_type val);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= val;
      do @(negedge clock); while (req_tready !== 1'b1);
      @(posedge clock);
      if (cmd <= CMD_FIND) items_sent++;
   endtask

   // response side: stall a random number of cycles after each transaction
   initial begin
      int stall;
      rsp_tready = 1'b1;
      wait (reset === 1'b0);
      forever begin
         do @(negedge clock); while (rsp_tvalid !== 1'b1 || rsp_tready !== 1'b1);
         @(posedge clock);
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // request side
   initial begin
      int               n;
      int               r;
      int               run_no;
      run_kind_type     kind;
      logic [CMD_W-1:0] cmd;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      gap_max    = 11;
      stall_max  = 11;
      items_sent = 0;
      value_pool[0] = VALUE_MAX;
      value_pool[1] = VALUE_MIN;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (int k = 4; k < 8; k++) value_pool[k] = value_type'($urandom);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty deque: both pops and a find are refused
      send(CMD_POP_FRONT, VALUE_MAX);
      send(CMD_POP_BACK, VALUE_MIN);
      send(CMD_FIND, '0);
      // extremes at both ends, hits, a miss and a duplicate
      send(CMD_PUSH_BACK, VALUE_MAX);
      send(CMD_PUSH_FRONT, VALUE_MIN);
      send(CMD_FIND, VALUE_MIN);
      send(CMD_FIND, VALUE_MAX);
      send(CMD_FIND, '0);
      send(CMD_PUSH_BACK, VALUE_MIN);
      send(CMD_FIND, VALUE_MIN);
      send(CMD_POP_BACK, '0);
      send(CMD_POP_FRONT, '0);
      // pop of the only element, from either end
      send(CMD_POP_BACK, -1);
      send(CMD_PUSH_FRONT, -1);
      send(CMD_POP_FRONT, '0);
      send(CMD_PUSH_BACK, '0);
      send(CMD_FIND, '0);
      // unused codes leave the deque alone
      for (int c = 0; c < 3; c++) send(CMD_W'(FIRST_UNUSED_CMD + c), VALUE_MAX);
      send(CMD_POP_FRONT, '0);
      send(FIRST_UNUSED_CMD, '0);

      // random runs; the first two fill the deque past full and drain it past empty
      run_no = 0;
      while (items_sent < ITEM_GOAL) begin
         if (run_no == 0)
            kind = RUN_FILL;
         else if (run_no == 1)
            kind = RUN_DRAIN;
         else
            kind = run_kind_type'($urandom_range(0, 3));
         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 11;
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         value_pool[$urandom_range(4, 7)] = value_type'($urandom);
         case (kind)
            RUN_FILL: begin
               n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
               repeat (n) begin
                  cmd = ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                  send(cmd, pick_value());
               end
            end
            RUN_DRAIN: begin
               n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
               repeat (n) begin
                  cmd = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
                  send(cmd, value_type'($urandom));
               end
            end
            RUN_MIXED: begin
               n = $urandom_range(10, 30);
               repeat (n) begin
                  r = $urandom_range(0, 19);
                  if (r < 4)       cmd = CMD_PUSH_FRONT;
                  else if (r < 8)  cmd = CMD_PUSH_BACK;
                  else if (r < 11) cmd = CMD_POP_FRONT;
                  else if (r < 14) cmd = CMD_POP_BACK;
                  else if (r < 19) cmd = CMD_FIND;
                  else             cmd = CMD_W'(FIRST_UNUSED_CMD + $urandom_range(0, 2));
                  send(cmd, pick_value());
               end
            end
            default: begin
               // search-heavy: pushes of pool values mixed with finds
               n = $urandom_range(10, 25);
               repeat (n) begin
                  r = $urandom_range(0, 9);
                  if (r < 6)      cmd = CMD_FIND;
                  else if (r < 8) cmd = CMD_PUSH_BACK;
                  else            cmd = CMD_PUSH_FRONT;
                  send(cmd, pick_value());
               end
            end
         endcase
         run_no++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding responses, then allow for the longest search
      wait (outcomes_waiting == 0);
      repeat (4 * CAPACITY) @(posedge clock);
      if (error_count == 0 && outcomes_waiting == 0)
         $display("[bounded_deque_with_search_core] OK");
      else
         $display("[bounded_deque_with_search_core] ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #10_000_000;
      $display("[bounded_deque_with_search_core] ERROR");
      $finish;
   end

endmodule
